// ===== src/bitmap_run_allocator_top_defines.svh =====
// Assertion macros for the bitmap run allocator.
// Included by the top level; no other dependencies.
`ifndef BITMAP_RUN_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_RUN_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTH
`define BRA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bitmap run allocator assertion failed");
`define BRA_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("bitmap run allocator assertion failed");
`else
`define BRA_ASSERT(lbl, clk, rst, prop)
`define BRA_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== src/bra_pkg.sv =====
// Shared constants, mode codes and result type of the bitmap run allocator.
// No dependencies.
`default_nettype none
package bra_pkg;
   localparam int CW = 12;   // bit index / count width
   localparam int WB = 32;   // bits per memory word
   localparam int OFF = 5;   // log2(WB)

   localparam logic [3:0] MODE_SET_RANGE   = 4'd0;
   localparam logic [3:0] MODE_CLR_RANGE   = 4'd1;
   localparam logic [3:0] MODE_TEST_CLR    = 4'd2;
   localparam logic [3:0] MODE_TEST_SET    = 4'd3;
   localparam logic [3:0] MODE_FIND_CLR    = 4'd4;
   localparam logic [3:0] MODE_FIND_SET    = 4'd5;
   localparam logic [3:0] MODE_ALLOC_CLR   = 4'd6;
   localparam logic [3:0] MODE_ALLOC_SET   = 4'd7;
   localparam logic [3:0] MODE_FIRST_CLR   = 4'd8;
   localparam logic [3:0] MODE_FIRST_SET   = 4'd9;
   localparam logic [3:0] MODE_LONG_CLR    = 4'd10;
   localparam logic [3:0] MODE_LONG_SET    = 4'd11;
   localparam logic [3:0] MODE_COUNT_CLR   = 4'd12;
   localparam logic [3:0] MODE_COUNT_SET   = 4'd13;
   localparam logic [3:0] MODE_SET_ALL     = 4'd14;
   localparam logic [3:0] MODE_CLR_ALL     = 4'd15;

   localparam logic [0:0] REG_BITMAP_SIZE  = 1'd0;
   localparam logic [10:0] SIZE_RESET      = 11'd1024;

   typedef struct packed {
      logic        ok;
      logic [9:0]  found_index;
      logic [10:0] bit_count;
   } res_type;
endpackage
`default_nettype wire

// ===== src/bra_if.sv =====
// Request and response channel interfaces of the bitmap run allocator.
// No dependencies.
`default_nettype none
interface bra_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  mode;
   logic [9:0]  start_index;
   logic [10:0] length;
   modport source (output valid, mode, start_index, length, input ready);
   modport sink (input valid, mode, start_index, length, output ready);
endinterface

interface bra_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [9:0]  found_index;
   logic [10:0] bit_count;
   modport source (output valid, ok, found_index, bit_count, input ready);
   modport sink (input valid, ok, found_index, bit_count, output ready);
endinterface
`default_nettype wire

// ===== src/bra_bitmem.sv =====
// Word-wide bit map storage: one write port, one registered read port.
// No dependencies.
`default_nettype none
module bra_bitmem #(
   parameter int NWORDS = 32,
   parameter int AW = 5,
   parameter int DW = 32
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic [AW-1:0] raddr,
   output logic      [DW-1:0] rd_data
);
   logic [DW-1:0] mem [NWORDS];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[raddr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== src/bra_seq.sv =====
// Sequencer and per-bit scan unit of the bitmap run allocator.
// Uses bra_pkg and drives the word memory bra_bitmem.
`default_nettype none
module bra_seq #(
   parameter int NWORDS = 32,
   parameter int AW = 5
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [bra_pkg::CW-1:0]  size_i,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [3:0]              req_mode,
   input  wire logic [9:0]              req_start,
   input  wire logic [10:0]             req_length,
   input  wire logic                    out_free,
   output logic                         res_push,
   output bra_pkg::res_type             res,
   output logic                         mem_we,
   output logic [AW-1:0]                mem_waddr,
   output logic [bra_pkg::WB-1:0]       mem_wdata,
   output logic [AW-1:0]                mem_raddr,
   input  wire logic [bra_pkg::WB-1:0]  mem_rdata
);
   localparam logic [2:0] ST_CLR   = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_FETCH = 3'd3;
   localparam logic [2:0] ST_BIT   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;
   localparam int CW = bra_pkg::CW;
   localparam int OFF = bra_pkg::OFF;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [3:0]    mode_ff, mode_in;
   logic [CW-1:0] i_ff, i_in, end_ff, end_in, len_ff, len_in;
   logic [CW-1:0] run_ff, run_in, cnt_ff, cnt_in, idx_ff, idx_in, rs_ff, rs_in;
   logic          phase_ff, phase_in, ok_ff, ok_in, dirty_ff, dirty_in;
   logic [bra_pkg::WB-1:0] word_ff, word_in, word_nx;

   logic          v, match, is_wr, wval, fin, jump, leave, dirty_nx;
   logic [CW-1:0] i_inc, run_p1, rs_nx;
   logic [CW-1:0] st12, len12, sum12, round8;

   assign v      = mode_ff[0];
   assign match  = (word_ff[i_ff[OFF-1:0]] == v);
   assign i_inc  = i_ff + CW'(1);
   assign run_p1 = run_ff + CW'(1);
   assign st12   = CW'(req_start);
   assign len12  = CW'(req_length);
   assign sum12  = st12 + len12;
   assign round8 = (size_i + CW'(7)) & ~CW'(7);

   assign req_ready = (state_ff == ST_IDLE);
   assign mem_raddr = AW'(i_ff[CW-1:OFF]);

   always_comb begin
      is_wr = (mode_ff inside {bra_pkg::MODE_SET_RANGE, bra_pkg::MODE_CLR_RANGE,
                               bra_pkg::MODE_SET_ALL, bra_pkg::MODE_CLR_ALL}) ||
              ((mode_ff inside {bra_pkg::MODE_ALLOC_CLR, bra_pkg::MODE_ALLOC_SET}) &&
               phase_ff);
      if (mode_ff == bra_pkg::MODE_SET_ALL) begin
         wval = 1'b1;
      end else if (mode_ff == bra_pkg::MODE_CLR_ALL) begin
         wval = 1'b0;
      end else begin
         wval = ~v;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      mode_in  = mode_ff;
      i_in     = i_ff;
      end_in   = end_ff;
      len_in   = len_ff;
      run_in   = run_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      rs_in    = rs_ff;
      phase_in = phase_ff;
      ok_in    = ok_ff;
      dirty_in = dirty_ff;
      word_in  = word_ff;
      word_nx  = word_ff;
      fin      = 1'b0;
      jump     = 1'b0;
      leave    = 1'b0;
      dirty_nx = dirty_ff;
      rs_nx    = rs_ff;
      mem_we    = 1'b0;
      mem_waddr = AW'(i_ff[CW-1:OFF]);
      mem_wdata = word_nx;
      res_push  = 1'b0;

      case (state_ff)
         ST_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(NWORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               len_in   = len12;
               run_in   = '0;
               cnt_in   = '0;
               idx_in   = '0;
               rs_in    = '0;
               phase_in = 1'b0;
               ok_in    = 1'b0;
               dirty_in = 1'b0;
               state_in = ST_DONE;
               case (req_mode)
                  bra_pkg::MODE_SET_RANGE, bra_pkg::MODE_CLR_RANGE: begin
                     if (st12 < size_i && len12 != '0) begin
                        i_in     = st12;
                        end_in   = (sum12 > size_i) ? size_i : sum12;
                        state_in = ST_LOAD;
                     end
                  end
                  bra_pkg::MODE_TEST_CLR, bra_pkg::MODE_TEST_SET: begin
                     if (st12 < size_i && len12 != '0 && sum12 <= size_i) begin
                        i_in     = st12;
                        end_in   = sum12;
                        state_in = ST_LOAD;
                     end
                  end
                  bra_pkg::MODE_FIND_CLR, bra_pkg::MODE_FIND_SET,
                  bra_pkg::MODE_ALLOC_CLR, bra_pkg::MODE_ALLOC_SET: begin
                     if (len12 != '0 && len12 <= size_i) begin
                        i_in     = (st12 < size_i) ? st12 : '0;
                        end_in   = size_i;
                        state_in = ST_LOAD;
                     end
                  end
                  bra_pkg::MODE_FIRST_CLR, bra_pkg::MODE_FIRST_SET: begin
                     if (st12 < size_i) begin
                        i_in     = st12;
                        end_in   = size_i;
                        state_in = ST_LOAD;
                     end
                  end
                  bra_pkg::MODE_SET_ALL, bra_pkg::MODE_CLR_ALL: begin
                     if (round8 != '0) begin
                        i_in     = '0;
                        end_in   = round8;
                        state_in = ST_LOAD;
                     end
                  end
                  default: begin
                     // longest run and counts scan the whole map
                     if (size_i != '0) begin
                        i_in     = '0;
                        end_in   = size_i;
                        state_in = ST_LOAD;
                     end
                  end
               endcase
            end
         end
         ST_LOAD: begin
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            word_in  = mem_rdata;
            state_in = ST_BIT;
         end
         ST_BIT: begin
            i_in = i_inc;
            if (is_wr) begin
               word_nx[i_ff[OFF-1:0]] = wval;
               dirty_nx = 1'b1;
            end else begin
               case (mode_ff)
                  bra_pkg::MODE_TEST_CLR, bra_pkg::MODE_TEST_SET: begin
                     if (!match) begin
                        fin = 1'b1;
                     end else if (i_inc == end_ff) begin
                        ok_in = 1'b1;
                     end
                  end
                  bra_pkg::MODE_FIND_CLR, bra_pkg::MODE_FIND_SET,
                  bra_pkg::MODE_ALLOC_CLR, bra_pkg::MODE_ALLOC_SET: begin
                     run_in = match ? run_p1 : '0;
                     if (match && run_p1 >= len_ff) begin
                        ok_in  = 1'b1;
                        idx_in = i_inc - len_ff;
                        cnt_in = len_ff;
                        if (mode_ff[1]) begin
                           // revisit the run and invert it
                           phase_in = 1'b1;
                           jump     = 1'b1;
                           i_in     = i_inc - len_ff;
                           end_in   = i_inc;
                        end else begin
                           fin = 1'b1;
                        end
                     end
                  end
                  bra_pkg::MODE_FIRST_CLR, bra_pkg::MODE_FIRST_SET: begin
                     if (!phase_ff) begin
                        if (match) begin
                           ok_in    = 1'b1;
                           idx_in   = i_ff;
                           cnt_in   = CW'(1);
                           phase_in = 1'b1;
                        end
                     end else if (match) begin
                        cnt_in = cnt_ff + CW'(1);
                     end else begin
                        fin = 1'b1;
                     end
                  end
                  bra_pkg::MODE_LONG_CLR, bra_pkg::MODE_LONG_SET: begin
                     if (match) begin
                        rs_nx  = (run_ff == '0) ? i_ff : rs_ff;
                        rs_in  = rs_nx;
                        run_in = run_p1;
                        if (run_p1 > cnt_ff) begin
                           cnt_in = run_p1;
                           idx_in = rs_nx;
                           ok_in  = 1'b1;
                        end
                     end else begin
                        run_in = '0;
                     end
                  end
                  default: begin
                     if (match) begin
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
               endcase
            end
            if (!jump && i_inc == end_ff) begin
               fin = 1'b1;
            end
            leave     = fin || jump || (i_inc[OFF-1:0] == '0);
            mem_wdata = word_nx;
            mem_we    = leave && dirty_nx;
            if (fin) begin
               state_in = ST_DONE;
               dirty_in = 1'b0;
            end else if (leave) begin
               state_in = ST_LOAD;
               dirty_in = 1'b0;
            end else begin
               word_in  = word_nx;
               dirty_in = dirty_nx;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               res_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res.ok          = ok_ff;
   assign res.found_index = idx_ff[9:0];
   assign res.bit_count   = cnt_ff[10:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      i_ff     <= i_in;
      end_ff   <= end_in;
      len_ff   <= len_in;
      run_ff   <= run_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      rs_ff    <= rs_in;
      phase_ff <= phase_in;
      ok_ff    <= ok_in;
      dirty_ff <= dirty_in;
      word_ff  <= word_in;
   end
endmodule
`default_nettype wire

// ===== src/bitmap_run_allocator_top.sv =====
// Bitmap run allocator: an item of work scans the bit map one bit per cycle,
// pausing to fetch each 32-bit word, in a shared test-and-update unit. Set
// all and clear all cover the size rounded up to bytes. The per-bit scan
// loop and the single memory read port set the speed of a request. After
// reset the map is cleared word by word before the first request is taken.
// Depends on bra_pkg, bra_if, bra_bitmem, bra_seq and the defines.
`default_nettype none
`include "bitmap_run_allocator_top_defines.svh"
module bitmap_run_allocator_top #(
   parameter int MAX_BITS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   bra_req_if.sink          req_ch,
   bra_rsp_if.source        rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int NWORDS = (MAX_BITS + bra_pkg::WB - 1) / bra_pkg::WB;
   localparam int AW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int CW = bra_pkg::CW;

   logic [10:0]          size_ff, size_in;
   logic [CW-1:0]        eff_size;
   logic                 rsp_valid_ff, rsp_valid_in, out_free, res_push;
   bra_pkg::res_type     res, rsp_data_ff, rsp_data_in;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic [bra_pkg::WB-1:0] mem_wdata, mem_rdata;

   // only one register: every write lands in bitmap_size
   assign csr_pready = 1'b1;
   assign csr_prdata = 32'(size_ff);
   assign size_in = (csr_psel && csr_penable && csr_pwrite &&
                     (csr_paddr[1] == bra_pkg::REG_BITMAP_SIZE ||
                      csr_paddr[1] != bra_pkg::REG_BITMAP_SIZE)) ?
                    csr_pwdata[10:0] : size_ff;
   assign eff_size = (32'(size_ff) < MAX_BITS) ? CW'(size_ff) : CW'(MAX_BITS);

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_valid_in = res_push ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = res_push ? res : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= bra_pkg::SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.ok          = rsp_data_ff.ok;
   assign rsp_ch.found_index = rsp_data_ff.found_index;
   assign rsp_ch.bit_count   = rsp_data_ff.bit_count;

   bra_bitmem #(.NWORDS(NWORDS), .AW(AW), .DW(bra_pkg::WB)) u_mem (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .raddr   (mem_raddr),
      .rd_data (mem_rdata)
   );

   bra_seq #(.NWORDS(NWORDS), .AW(AW)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .size_i     (eff_size),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_mode   (req_ch.mode),
      .req_start  (req_ch.start_index),
      .req_length (req_ch.length),
      .out_free   (out_free),
      .res_push   (res_push),
      .res        (res),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   `BRA_ASSERT(a_busy_after_accept, clock, reset, (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
   `BRA_ASSERT(a_push_into_free_slot, clock, reset, res_push |-> out_free)
   `BRA_ASSERT_NR(a_clear_after_reset, clock, reset |=> !req_ch.ready)
endmodule
`default_nettype wire
